/* rtl/core/scd_pkg.sv */
package scd_pkg;

	// Pipeline depth: two stages split seconds into days and time of day,
	// six more build the date and the clock fields.
	localparam int STAGES = 8;

	// Seconds to days: drop the factor 128 by shifting, then divide by 675.
	localparam int SECS_SHIFT = 7;
	localparam int DAY_DIV    = 675;
	localparam int DAY_REC_K  = 35;
	localparam logic [25:0] DAY_REC = 26'((64'd1 << DAY_REC_K) / DAY_DIV);

	// Julian day of the epoch plus the offset of the conversion
	localparam int JD_EPOCH   = 2440588;
	localparam int JD_OFFSET  = 32044;
	localparam logic [21:0] JD_A_OFS = 22'(JD_EPOCH + JD_OFFSET);

	// Quad-century step: the 32-bit input keeps the count between 67 and 69
	localparam int DAYS_400Y  = 146097;
	localparam int CENT_LO    = 67;
	localparam logic [23:0] CENT_SUB_LO  = 24'(CENT_LO * DAYS_400Y);
	localparam logic [23:0] CENT_SUB_MID = 24'((CENT_LO + 1) * DAYS_400Y);
	localparam logic [23:0] CENT_SUB_HI  = 24'((CENT_LO + 2) * DAYS_400Y);
	localparam int YEAR_BIAS  = 4800;
	localparam logic [11:0] YEAR_BASE_LO  = 12'(100 * CENT_LO - YEAR_BIAS);
	localparam logic [11:0] YEAR_BASE_MID = 12'(100 * (CENT_LO + 1) - YEAR_BIAS);
	localparam logic [11:0] YEAR_BASE_HI  = 12'(100 * (CENT_LO + 2) - YEAR_BIAS);

	// Four-year step
	localparam int DAYS_4Y    = 1461;
	localparam int D_REC_K    = 29;
	localparam logic [18:0] D_REC = 19'((64'd1 << D_REC_K) / DAYS_4Y);

	// Month step
	localparam int MONTH_DIV  = 153;
	localparam int M_REC_K    = 16;
	localparam logic [8:0] M_REC = 9'((64'd1 << M_REC_K) / MONTH_DIV);
	localparam int MONTH_WRAP = 10;

	// Exact division by five for values below 1024
	localparam int DIV5_K     = 10;
	localparam logic [7:0] DIV5_REC = 8'((1 << DIV5_K) / 5 + 1);

	// Division by 15 for the minute and hour steps
	localparam int MIN_DIV    = 15;
	localparam int TM_REC_K   = 19;
	localparam logic [15:0] TM_REC = 16'((64'd1 << TM_REC_K) / MIN_DIV);
	localparam int HR_REC_K   = 13;
	localparam logic [9:0] HR_REC = 10'((64'd1 << HR_REC_K) / MIN_DIV);

	// Weekday: Julian day modulo 7, with Monday as zero
	localparam int WEEK_DAYS  = 7;
	localparam logic [15:0] WD_OFS = 16'(JD_EPOCH % WEEK_DAYS);
	localparam int WD_REC_K   = 19;
	localparam logic [16:0] WD_REC = 17'((64'd1 << WD_REC_K) / WEEK_DAYS);

	typedef struct packed {
		logic [STAGES-1:0] load;
		logic [STAGES-1:0] valid;
	} pipe_ctrl_t;

endpackage

/* rtl/core/scd_in_if.sv */
interface scd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] seconds_count;

	modport source (output valid, output seconds_count, input ready);
	modport sink (input valid, input seconds_count, output ready);
endinterface

/* rtl/core/scd_out_if.sv */
interface scd_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [2:0]  weekday;

	modport source (
		output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, output weekday,
		input ready
	);
	modport sink (
		input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, input weekday,
		output ready
	);
endinterface

/* rtl/core/scd_pipe_ctrl.sv */
module scd_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	output scd_pkg::pipe_ctrl_t ctrl
);

	logic [scd_pkg::STAGES-1:0] valid_q;
	logic [scd_pkg::STAGES-1:0] load;

	// A stage takes new data when it is empty or its content moves on
	always_comb begin
		load[scd_pkg::STAGES-1] = !valid_q[scd_pkg::STAGES-1] || out_ready;
		for (int k = scd_pkg::STAGES - 2; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (load & {valid_q[scd_pkg::STAGES-2:0], in_valid}) | (~load & valid_q);
		end
	end

	assign ctrl.load  = load;
	assign ctrl.valid = valid_q;

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(&valid_q) |-> load[0])
		else $error("input stalled while the pipeline has an empty stage");

	a_load_backward: assert property (@(posedge clk) disable iff (!arst_n)
		((load >> 1) & ~load) == '0)
		else $error("stage advances while the stage before it holds");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && load[0] && !(valid_q[scd_pkg::STAGES-1] && out_ready))
		|=> $countones(valid_q) == $past($countones(valid_q)) + 1)
		else $error("request lost or duplicated on entry");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && load[0]) && valid_q[scd_pkg::STAGES-1] && out_ready)
		|=> $countones(valid_q) + 1 == $past($countones(valid_q)))
		else $error("request lost or duplicated on exit");

endmodule

/* rtl/core/scd_date_path.sv */
module scd_date_path (
	input  logic                clk,
	input  scd_pkg::pipe_ctrl_t ctrl,
	input  logic [15:0]         days_s2,
	output logic [11:0]         year_s8,
	output logic [3:0]          month_s8,
	output logic [4:0]          mday_s8
);

	// Stage 3: quad-century count by compare, remainder within it
	logic [21:0] jd_a;
	logic [23:0] x4;
	logic        ge_mid, ge_hi;
	logic [23:0] cent_sub;
	logic [11:0] year_base;
	logic [23:0] cent_rem;
	logic [15:0] c_s3;
	logic [11:0] yb_s3;

	assign jd_a   = 22'(days_s2) + scd_pkg::JD_A_OFS;
	assign x4     = {jd_a, 2'b11};
	assign ge_mid = x4 >= scd_pkg::CENT_SUB_MID;
	assign ge_hi  = x4 >= scd_pkg::CENT_SUB_HI;
	assign cent_sub  = ge_hi ? scd_pkg::CENT_SUB_HI :
		(ge_mid ? scd_pkg::CENT_SUB_MID : scd_pkg::CENT_SUB_LO);
	assign year_base = ge_hi ? scd_pkg::YEAR_BASE_HI :
		(ge_mid ? scd_pkg::YEAR_BASE_MID : scd_pkg::YEAR_BASE_LO);
	assign cent_rem  = x4 - cent_sub;

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			c_s3  <= cent_rem[17:2];
			yb_s3 <= year_base;
		end
	end

	// Stage 4: estimate of the four-year count
	logic [17:0] xd;
	logic [36:0] d_prod;
	logic [17:0] xd_s4;
	logic [6:0]  dq0_s4;
	logic [11:0] yb_s4;

	assign xd     = {c_s3, 2'b11};
	assign d_prod = 37'(xd) * 37'(scd_pkg::D_REC);

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			xd_s4  <= xd;
			dq0_s4 <= d_prod[35:29];
			yb_s4  <= yb_s3;
		end
	end

	// Stage 5: correct the estimate; day of the year is the remainder over four
	logic [17:0] d_back, d_rem;
	logic        d_fix;
	logic [11:0] d_rem_fixed;
	logic [8:0]  e_s5;
	logic [6:0]  d_s5;
	logic [11:0] yb_s5;

	assign d_back = 18'(18'(dq0_s4) * 18'(scd_pkg::DAYS_4Y));
	assign d_rem  = xd_s4 - d_back;
	assign d_fix  = d_rem[11:0] >= 12'(scd_pkg::DAYS_4Y);
	assign d_rem_fixed = d_fix ? (d_rem[11:0] - 12'(scd_pkg::DAYS_4Y)) : d_rem[11:0];

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			e_s5  <= d_rem_fixed[10:2];
			d_s5  <= dq0_s4 + 7'(d_fix);
			yb_s5 <= yb_s4;
		end
	end

	// Stage 6: estimate of the month index
	logic [10:0] x5;
	logic [19:0] m_prod;
	logic [10:0] x5_s6;
	logic [3:0]  mq0_s6;
	logic [6:0]  d_s6;
	logic [11:0] yb_s6;

	assign x5     = 11'({e_s5, 2'b00}) + 11'(e_s5) + 11'd2;
	assign m_prod = 20'(x5) * 20'(scd_pkg::M_REC);

	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			x5_s6  <= x5;
			mq0_s6 <= m_prod[19:16];
			d_s6   <= d_s5;
			yb_s6  <= yb_s5;
		end
	end

	// Stage 7: correct the month index, keep the remainder for the day
	logic [10:0] m_back, m_rem;
	logic        m_fix;
	logic [8:0]  m_rem_fixed;
	logic [3:0]  m_s7;
	logic [7:0]  rr_s7;
	logic [6:0]  d_s7;
	logic [11:0] yb_s7;

	assign m_back = 11'(11'(mq0_s6) * 11'(scd_pkg::MONTH_DIV));
	assign m_rem  = x5_s6 - m_back;
	assign m_fix  = m_rem[8:0] >= 9'(scd_pkg::MONTH_DIV);
	assign m_rem_fixed = m_fix ? (m_rem[8:0] - 9'(scd_pkg::MONTH_DIV)) : m_rem[8:0];

	always_ff @(posedge clk) begin
		if (ctrl.load[6]) begin
			m_s7  <= mq0_s6 + 4'(m_fix);
			rr_s7 <= m_rem_fixed[7:0];
			d_s7  <= d_s6;
			yb_s7 <= yb_s6;
		end
	end

	// Stage 8: day of month, month and year; March-based months wrap into next year
	logic [15:0] q5_prod;
	logic        wrap;

	assign q5_prod = 16'(rr_s7) * 16'(scd_pkg::DIV5_REC);
	assign wrap    = m_s7 >= 4'(scd_pkg::MONTH_WRAP);

	always_ff @(posedge clk) begin
		if (ctrl.load[7]) begin
			mday_s8  <= q5_prod[14:10] + 5'd1;
			month_s8 <= wrap ? (m_s7 - 4'd9) : (m_s7 + 4'd3);
			year_s8  <= yb_s7 + 12'(d_s7) + 12'(wrap);
		end
	end

endmodule

/* rtl/core/scd_clock_path.sv */
module scd_clock_path (
	input  logic                clk,
	input  scd_pkg::pipe_ctrl_t ctrl,
	input  logic [15:0]         days_s2,
	input  logic [16:0]         tod_s2,
	output logic [4:0]          hour_s8,
	output logic [5:0]          minute_s8,
	output logic [5:0]          second_s8,
	output logic [2:0]          weekday_s8
);

	// Stage 3: estimates of minutes of the day and of weeks
	logic [14:0] tod_hi;
	logic [30:0] t_prod;
	logic [15:0] w;
	logic [32:0] w_prod;
	logic [14:0] y_s3;
	logic [1:0]  slo_s3;
	logic [10:0] tq0_s3;
	logic [15:0] w_s3;
	logic [13:0] wq0_s3;

	assign tod_hi = tod_s2[16:2];
	assign t_prod = 31'(tod_hi) * 31'(scd_pkg::TM_REC);
	assign w      = days_s2 + scd_pkg::WD_OFS;
	assign w_prod = 33'(w) * 33'(scd_pkg::WD_REC);

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			y_s3   <= tod_hi;
			slo_s3 <= tod_s2[1:0];
			tq0_s3 <= t_prod[29:19];
			w_s3   <= w;
			wq0_s3 <= w_prod[32:19];
		end
	end

	// Stage 4: correct both estimates; seconds and weekday fall out
	logic [14:0] t_rem;
	logic        t_fix;
	logic [4:0]  t_rem_fixed;
	logic [15:0] w_rem;
	logic        w_fix;
	logic [3:0]  w_rem_fixed;
	logic [10:0] tm_s4;
	logic [5:0]  sec_s4;
	logic [2:0]  wd_s4;

	assign t_rem = y_s3 - 15'(15'(tq0_s3) * 15'(scd_pkg::MIN_DIV));
	assign t_fix = t_rem[4:0] >= 5'(scd_pkg::MIN_DIV);
	assign t_rem_fixed = t_fix ? (t_rem[4:0] - 5'(scd_pkg::MIN_DIV)) : t_rem[4:0];
	assign w_rem = w_s3 - 16'(16'(wq0_s3) * 16'(scd_pkg::WEEK_DAYS));
	assign w_fix = w_rem[3:0] >= 4'(scd_pkg::WEEK_DAYS);
	assign w_rem_fixed = w_fix ? (w_rem[3:0] - 4'(scd_pkg::WEEK_DAYS)) : w_rem[3:0];

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			tm_s4  <= tq0_s3 + 11'(t_fix);
			sec_s4 <= {t_rem_fixed[3:0], slo_s3};
			wd_s4  <= w_rem_fixed[2:0];
		end
	end

	// Stage 5: estimate of hours
	logic [8:0]  z;
	logic [18:0] h_prod;
	logic [8:0]  z_s5;
	logic [1:0]  mlo_s5;
	logic [4:0]  hq0_s5;
	logic [5:0]  sec_s5;
	logic [2:0]  wd_s5;

	assign z      = tm_s4[10:2];
	assign h_prod = 19'(z) * 19'(scd_pkg::HR_REC);

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			z_s5   <= z;
			mlo_s5 <= tm_s4[1:0];
			hq0_s5 <= h_prod[17:13];
			sec_s5 <= sec_s4;
			wd_s5  <= wd_s4;
		end
	end

	// Stage 6: correct hours; minutes are the remainder
	logic [8:0] h_rem;
	logic       h_fix;
	logic [4:0] h_rem_fixed;
	logic [4:0] hour_s6;
	logic [5:0] minute_s6;
	logic [5:0] sec_s6;
	logic [2:0] wd_s6;

	assign h_rem = z_s5 - 9'(9'(hq0_s5) * 9'(scd_pkg::MIN_DIV));
	assign h_fix = h_rem[4:0] >= 5'(scd_pkg::MIN_DIV);
	assign h_rem_fixed = h_fix ? (h_rem[4:0] - 5'(scd_pkg::MIN_DIV)) : h_rem[4:0];

	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			hour_s6   <= hq0_s5 + 5'(h_fix);
			minute_s6 <= {h_rem_fixed[3:0], mlo_s5};
			sec_s6    <= sec_s5;
			wd_s6     <= wd_s5;
		end
	end

	// Stages 7 and 8: hold in step with the date path
	logic [4:0] hour_s7;
	logic [5:0] minute_s7;
	logic [5:0] sec_s7;
	logic [2:0] wd_s7;

	always_ff @(posedge clk) begin
		if (ctrl.load[6]) begin
			hour_s7   <= hour_s6;
			minute_s7 <= minute_s6;
			sec_s7    <= sec_s6;
			wd_s7     <= wd_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[7]) begin
			hour_s8    <= hour_s7;
			minute_s8  <= minute_s7;
			second_s8  <= sec_s7;
			weekday_s8 <= wd_s7;
		end
	end

endmodule

/* rtl/core/seconds_to_calendar_date_core.sv */
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the Gregorian
// date (year, month, day of month), the time of day and the weekday (0 is Monday).
// The block is an eight-stage pipeline: it takes one request per clock while the
// output side keeps taking results. Divisions by a constant are done as a reciprocal
// multiply followed by a one-step correction in the next stage, except for the
// quad-century step, done by compares, and the exact division by five. The depth is
// set by the chain of such steps from seconds to days to the month index. A stall on
// the output holds only the stages that are full, so empty stages keep filling.
module seconds_to_calendar_date_core (
	input  logic      clk,
	input  logic      arst_n,
	scd_in_if.sink    timestamp,
	scd_out_if.source calendar
);

	scd_pkg::pipe_ctrl_t ctrl;

	scd_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (timestamp.valid),
		.out_ready (calendar.ready),
		.ctrl      (ctrl)
	);

	assign timestamp.ready = ctrl.load[0];

	// Stage 1: estimate of whole days from the seconds divided by 128
	logic [50:0] day_prod;
	logic [31:0] secs_s1;
	logic [15:0] dq0_s1;

	assign day_prod = 51'(timestamp.seconds_count[31:scd_pkg::SECS_SHIFT])
		* 51'(scd_pkg::DAY_REC);

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			secs_s1 <= timestamp.seconds_count;
			dq0_s1  <= day_prod[50:35];
		end
	end

	// Stage 2: correct the day count; time of day is the remainder
	logic [24:0] day_rem;
	logic        day_fix;
	logic [9:0]  day_rem_fixed;
	logic [15:0] days_s2;
	logic [16:0] tod_s2;

	assign day_rem = secs_s1[31:scd_pkg::SECS_SHIFT]
		- 25'(26'(dq0_s1) * 26'(scd_pkg::DAY_DIV));
	assign day_fix = day_rem[10:0] >= 11'(scd_pkg::DAY_DIV);
	assign day_rem_fixed = day_fix ? 10'(day_rem[10:0] - 11'(scd_pkg::DAY_DIV))
		: day_rem[9:0];

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			days_s2 <= dq0_s1 + 16'(day_fix);
			tod_s2  <= {day_rem_fixed, secs_s1[scd_pkg::SECS_SHIFT-1:0]};
		end
	end

	logic [11:0] year_s8;
	logic [3:0]  month_s8;
	logic [4:0]  mday_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  minute_s8;
	logic [5:0]  second_s8;
	logic [2:0]  weekday_s8;

	scd_date_path u_date (
		.clk      (clk),
		.ctrl     (ctrl),
		.days_s2  (days_s2),
		.year_s8  (year_s8),
		.month_s8 (month_s8),
		.mday_s8  (mday_s8)
	);

	scd_clock_path u_clock (
		.clk        (clk),
		.ctrl       (ctrl),
		.days_s2    (days_s2),
		.tod_s2     (tod_s2),
		.hour_s8    (hour_s8),
		.minute_s8  (minute_s8),
		.second_s8  (second_s8),
		.weekday_s8 (weekday_s8)
	);

	assign calendar.valid        = ctrl.valid[scd_pkg::STAGES-1];
	assign calendar.year         = year_s8;
	assign calendar.month        = month_s8;
	assign calendar.day_of_month = mday_s8;
	assign calendar.hour         = hour_s8;
	assign calendar.minute       = minute_s8;
	assign calendar.second       = second_s8;
	assign calendar.weekday      = weekday_s8;

endmodule

/* sim/seconds_to_calendar_date_core_tb.sv */
module seconds_to_calendar_date_core_tb;

	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned JDN_EPOCH    = 2440588;
	localparam int unsigned JDN_SHIFT    = 32044;
	localparam int unsigned QUAD_CENT    = 146097;
	localparam int unsigned QUAD_YEAR    = 1461;
	localparam int unsigned MONTH_SPAN   = 153;
	localparam int unsigned YEAR_OFS     = 4800;
	localparam int unsigned LAST_DAY     = 49709;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
	} date_t;

	typedef struct packed {
		logic [31:0] secs;
		logic        fixed;
		date_t       want;
	} stamp_row_t;

	typedef struct {
		logic [31:0] secs;
		date_t       want;
	} due_t;

	localparam date_t NO_DATE = '0;
	localparam int NUM_ROWS = 21;

	// Hand-checked rows carry their date; the rest go through the predictor.
	localparam stamp_row_t STAMP_ROWS [NUM_ROWS] = '{
		'{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd3}},
		'{32'd1,          1'b0, NO_DATE},
		'{32'd59,         1'b0, NO_DATE},
		'{32'd3599,       1'b0, NO_DATE},
		'{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 3'd3}},
		'{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0, 3'd4}},
		'{32'd31535999,   1'b0, NO_DATE},
		'{32'd31536000,   1'b0, NO_DATE},
		'{32'd68169600,   1'b0, NO_DATE},
		'{32'd951782399,  1'b0, NO_DATE},
		'{32'd951782400,  1'b1, '{12'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 3'd1}},
		'{32'd2147483647, 1'b1, '{12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7, 3'd1}},
		'{32'd2147483648, 1'b0, NO_DATE},
		'{32'd4107542399, 1'b0, NO_DATE},
		'{32'd4107542400, 1'b0, NO_DATE},
		'{32'd4291747199, 1'b0, NO_DATE},
		'{32'd4291747200, 1'b0, NO_DATE},
		'{32'd4294944000, 1'b0, NO_DATE},
		'{32'hAAAA_AAAA,  1'b0, NO_DATE},
		'{32'h5555_5555,  1'b0, NO_DATE},
		'{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 3'd6}}
	};

	logic clk;
	logic arst_n;

	scd_in_if  stamp_in ();
	scd_out_if date_out ();

	seconds_to_calendar_date_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.timestamp(stamp_in),
		.calendar (date_out)
	);

	due_t dates_due [$];
	int   err_count;
	int   cycle_count;
	int   src_idle_pct;
	int   snk_stall_pct;
	logic hold_req;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic date_t gregorian_of(input logic [31:0] secs);
		int unsigned days, tod, jdn, a, b, c, d, e, m, wrap, yr, mon, mday;
		date_t r;
		days = secs / SECS_PER_DAY;
		tod  = secs - days * SECS_PER_DAY;
		jdn  = days + JDN_EPOCH;
		a    = jdn + JDN_SHIFT;
		b    = (4 * a + 3) / QUAD_CENT;
		c    = a - (QUAD_CENT * b) / 4;
		d    = (4 * c + 3) / QUAD_YEAR;
		e    = c - (QUAD_YEAR * d) / 4;
		m    = (5 * e + 2) / MONTH_SPAN;
		wrap = m / 10;
		mday = e - (MONTH_SPAN * m + 2) / 5 + 1;
		mon  = m + 3 - 12 * wrap;
		yr   = 100 * b + d + wrap - YEAR_OFS;
		r.year         = 12'(yr);
		r.month        = 4'(mon);
		r.day_of_month = 5'(mday);
		r.hour         = 5'(tod / 3600);
		r.minute       = 6'((tod / 60) % 60);
		r.second       = 6'(tod % 60);
		r.weekday      = 3'(jdn % 7);
		return r;
	endfunction

	// Mix plain random stamps with ones on day, year and leap-day edges and near the top.
	function automatic logic [31:0] pick_seconds();
		int unsigned yr, days, leap;
		logic [31:0] s;
		case ($urandom_range(3))
			0: begin
				s = $urandom;
			end
			1: begin
				days = $urandom_range(LAST_DAY);
				case ($urandom_range(2))
					0: s = days * SECS_PER_DAY;
					1: s = days * SECS_PER_DAY + SECS_PER_DAY - 1;
					default: s = days * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1);
				endcase
			end
			2: begin
				yr   = $urandom_range(2105, 1970);
				leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
				days = 365 * (yr - 1970)
					+ ((yr - 1) / 4 - 1969 / 4)
					- ((yr - 1) / 100 - 1969 / 100)
					+ ((yr - 1) / 400 - 1969 / 400);
				if ($urandom_range(1))
					days = days + 59 + leap;
				s = days * SECS_PER_DAY - $urandom_range(1);
			end
			default: begin
				s = 32'hFFFF_FFFF - $urandom_range(200000000);
			end
		endcase
		return s;
	endfunction

	task automatic report_error(input string what);
		$display("ERROR @%0t: %s", $time, what);
		err_count++;
	endtask

	task automatic cmp_field(input logic [31:0] secs, input string name,
			input logic [11:0] got, input logic [11:0] want);
		if (got !== want)
			report_error($sformatf("seconds %0d: %s got %0d expected %0d",
				secs, name, got, want));
	endtask

	task automatic check_result();
		date_t got;
		due_t  due;
		got = '{date_out.year, date_out.month, date_out.day_of_month, date_out.hour,
			date_out.minute, date_out.second, date_out.weekday};
		if (dates_due.size() == 0) begin
			report_error($sformatf("unexpected result %0d-%0d-%0d %0d:%0d:%0d",
				got.year, got.month, got.day_of_month, got.hour, got.minute, got.second));
			return;
		end
		due = dates_due.pop_front();
		cmp_field(due.secs, "year",         got.year,         due.want.year);
		cmp_field(due.secs, "month",        got.month,        due.want.month);
		cmp_field(due.secs, "day_of_month", got.day_of_month, due.want.day_of_month);
		cmp_field(due.secs, "hour",         got.hour,         due.want.hour);
		cmp_field(due.secs, "minute",       got.minute,       due.want.minute);
		cmp_field(due.secs, "second",       got.second,       due.want.second);
		cmp_field(due.secs, "weekday",      got.weekday,      due.want.weekday);
	endtask

	// Call at a rising edge; returns at the edge where the request is taken.
	task automatic offer(input logic [31:0] secs, input logic fixed, input date_t want);
		due_t due;
		if ($urandom_range(99) < src_idle_pct) begin
			stamp_in.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		stamp_in.valid         <= 1'b1;
		stamp_in.seconds_count <= secs;
		do @(posedge clk); while (stamp_in.ready !== 1'b1);
		due.secs = secs;
		due.want = fixed ? want : gregorian_of(secs);
		dates_due.push_back(due);
	endtask

	task automatic offer_random(input int count);
		for (int i = 0; i < count; i++)
			offer(pick_seconds(), 1'b0, NO_DATE);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, dates_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : sink_side
		int  hold_left;
		logic hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		date_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (date_out.valid === 1'b1 && date_out.ready === 1'b1)
				check_result();
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				date_out.ready <= 1'b0;
			end else begin
				date_out.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	initial begin
		err_count     = 0;
		cycle_count   = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_req      = 1'b0;
		arst_n                 <= 1'b0;
		stamp_in.valid         <= 1'b0;
		stamp_in.seconds_count <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (STAMP_ROWS[i])
			offer(STAMP_ROWS[i].secs, STAMP_ROWS[i].fixed, STAMP_ROWS[i].want);

		offer_random(140);

		src_idle_pct = 80;
		offer_random(140);

		src_idle_pct = 0;
		snk_stall_pct <= 80;
		offer_random(140);

		src_idle_pct = 32;
		snk_stall_pct <= 32;
		offer_random(140);

		// Hold the output off for a long stretch and keep pushing requests.
		src_idle_pct = 0;
		snk_stall_pct <= 0;
		hold_req      <= 1'b1;
		offer_random(40);

		stamp_in.valid <= 1'b0;
		while (dates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/scd_pkg.sv
rtl/core/scd_in_if.sv
rtl/core/scd_out_if.sv
rtl/core/scd_pipe_ctrl.sv
rtl/core/scd_date_path.sv
rtl/core/scd_clock_path.sv
rtl/core/seconds_to_calendar_date_core.sv
sim/seconds_to_calendar_date_core_tb.sv
